// File: src/matrix_inverse_3x3_core_macros.svh
// Assertion macros shared by the matrix inverse core.
// Needs clk and rst_n in the scope of use; no other dependencies.
`ifndef MATRIX_INVERSE_3X3_CORE_MACROS_SVH
`define MATRIX_INVERSE_3X3_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MIT_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MIT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/mit_pkg.sv
// Package for the 3x3 matrix inverse core: widths, payload types, cofactor table.
// No dependencies.
package mit_pkg;

    localparam int FIELD_W        = 16;
    localparam int THR_W          = 24;
    localparam int OUT_W          = 32;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int ELEM_WIDTH_MAX = 32;

    // element after load: 16-bit field, sign-extended or read as non-negative
    localparam int A_W    = FIELD_W + 1;
    localparam int P_W    = 2 * A_W;
    localparam int C_W    = P_W + 1;
    localparam int DP_W   = A_W + C_W;
    localparam int DET_W  = DP_W + 2;
    localparam int MAG_W  = DET_W;
    localparam int SCALE  = 24;
    localparam int Q_W    = OUT_W;
    localparam int R_W    = MAG_W + Q_W;
    localparam int NLANE  = 9;
    localparam int NPROD  = 2 * NLANE;

    localparam int FRONT_ST = 5;
    localparam int DIV_ST   = Q_W;
    localparam int LANE_ST  = DIV_ST + 2;
    localparam int NST      = FRONT_ST + LANE_ST;

    // cofactor c = a[i]*a[j] - a[k]*a[l], flat row-major element indices
    localparam int CF_IDX [NLANE][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] a00;
        logic signed [FIELD_W-1:0] a01;
        logic signed [FIELD_W-1:0] a02;
        logic signed [FIELD_W-1:0] a10;
        logic signed [FIELD_W-1:0] a11;
        logic signed [FIELD_W-1:0] a12;
        logic signed [FIELD_W-1:0] a20;
        logic signed [FIELD_W-1:0] a21;
        logic signed [FIELD_W-1:0] a22;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] r00;
        logic signed [OUT_W-1:0] r01;
        logic signed [OUT_W-1:0] r02;
        logic signed [OUT_W-1:0] r10;
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r20;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
        logic                    invertible;
        logic                    saturated;
    } out_t;

    // determinant summary handed from the front end to every lane
    typedef struct packed {
        logic             inv;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } det_t;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } lane_res_t;

endpackage

// File: src/mit_if.sv
// Handshake channels of the matrix inverse core (valid/ready plus payload).
// Depends on mit_pkg.
interface mit_in_if;
    import mit_pkg::*;
    logic valid;
    logic ready;
    in_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mit_out_if;
    import mit_pkg::*;
    logic valid;
    logic ready;
    out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/mit_front.sv
// Front end: element load, cofactor products, adjugate, determinant, singular test.
// Depends on mit_pkg; five pipeline stages moved by en.
module mit_front #(
    parameter int ELEM_WIDTH = mit_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic [mit_pkg::FRONT_ST-1:0]                  en,
    input  mit_pkg::in_t                                  mat,
    input  logic [mit_pkg::THR_W-1:0]                     thr,
    output logic [mit_pkg::NLANE-1:0][mit_pkg::C_W-1:0]   cof,
    output mit_pkg::det_t                                 det
);
    import mit_pkg::*;

    logic [FIELD_W-1:0]      raw [NLANE];
    logic signed [A_W-1:0]   a_reg [NLANE];
    logic signed [P_W-1:0]   prod_reg [NPROD];
    logic signed [A_W-1:0]   row1_reg [3];
    logic signed [A_W-1:0]   row2_reg [3];
    logic signed [C_W-1:0]   cof2_reg [NLANE];
    logic signed [C_W-1:0]   cof3_reg [NLANE];
    logic signed [C_W-1:0]   cof4_reg [NLANE];
    logic signed [DP_W-1:0]  dp_reg [3];
    logic signed [DET_W-1:0] det_next;
    logic [MAG_W-1:0]        mag_next;
    det_t                    det_reg;

    assign raw[0] = mat.a00;
    assign raw[1] = mat.a01;
    assign raw[2] = mat.a02;
    assign raw[3] = mat.a10;
    assign raw[4] = mat.a11;
    assign raw[5] = mat.a12;
    assign raw[6] = mat.a20;
    assign raw[7] = mat.a21;
    assign raw[8] = mat.a22;

    for (genvar e = 0; e < NLANE; e++)
    begin : g_load
        logic signed [A_W-1:0] elem;
        if (ELEM_WIDTH > FIELD_W)
        begin : g_wide
            assign elem = signed'({1'b0, raw[e]});
        end
        else
        begin : g_narrow
            assign elem = A_W'(signed'(raw[e][ELEM_WIDTH-1:0]));
        end
        always_ff @(posedge clk)
        begin
            if (en[0])
                a_reg[e] <= elem;
        end
    end

    for (genvar g = 0; g < NLANE; g++)
    begin : g_cof
        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                prod_reg[2*g]   <= a_reg[CF_IDX[g][0]] * a_reg[CF_IDX[g][1]];
                prod_reg[2*g+1] <= a_reg[CF_IDX[g][2]] * a_reg[CF_IDX[g][3]];
            end
            if (en[2])
                cof2_reg[g] <= C_W'(prod_reg[2*g]) - C_W'(prod_reg[2*g+1]);
            if (en[3])
                cof3_reg[g] <= cof2_reg[g];
            if (en[4])
                cof4_reg[g] <= cof3_reg[g];
        end
        assign cof[g] = cof4_reg[g];
    end

    // first row rides along to meet the first adjugate column
    for (genvar k = 0; k < 3; k++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (en[1])
                row1_reg[k] <= a_reg[k];
            if (en[2])
                row2_reg[k] <= row1_reg[k];
            if (en[3])
                dp_reg[k] <= DP_W'(row2_reg[k]) * DP_W'(cof2_reg[3*k]);
        end
    end

    always_comb
    begin
        det_next = DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
        mag_next = det_next[DET_W-1] ? MAG_W'(-det_next) : MAG_W'(det_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            det_reg.mag <= mag_next;
            det_reg.neg <= det_next[DET_W-1];
            det_reg.inv <= mag_next > MAG_W'(thr);
        end
    end

    assign det = det_reg;

endmodule

// File: src/mit_lane.sv
// One division lane: |adj| * 2^24 / |det|, one quotient bit per stage, then sign and clip.
// Depends on mit_pkg; LANE_ST pipeline stages moved by en.
module mit_lane (
    input  logic                          clk,
    input  logic [mit_pkg::LANE_ST-1:0]   en,
    input  logic [mit_pkg::C_W-1:0]       cof,
    input  mit_pkg::det_t                 det,
    output mit_pkg::lane_res_t            res
);
    import mit_pkg::*;

    logic [R_W-1:0]   rem_reg  [DIV_ST+1];
    logic [Q_W-1:0]   q_reg    [DIV_ST+1];
    logic [MAG_W-1:0] dmag_reg [DIV_ST+1];
    logic [C_W-1:0]   cof_reg  [DIV_ST+1];
    logic             neg_reg  [DIV_ST+1];
    logic             ovf_reg  [DIV_ST+1];
    logic             inv_reg  [DIV_ST+1];
    logic [C_W-1:0]   cmag;
    logic [R_W-1:0]   num;
    lane_res_t        res_next;
    lane_res_t        res_reg;

    assign cmag = cof[C_W-1] ? -cof : cof;
    assign num  = R_W'(cmag) << SCALE;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= num;
            q_reg[0]    <= '0;
            dmag_reg[0] <= det.mag;
            cof_reg[0]  <= cof;
            neg_reg[0]  <= cof[C_W-1] ^ det.neg;
            ovf_reg[0]  <= num >= (R_W'(det.mag) << Q_W);
            inv_reg[0]  <= det.inv;
        end
    end

    for (genvar s = 1; s <= DIV_ST; s++)
    begin : g_div
        logic [R_W-1:0] dsh;
        logic           take;
        assign dsh  = R_W'(dmag_reg[s-1]) << (Q_W - s);
        assign take = rem_reg[s-1] >= dsh;
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= take ? rem_reg[s-1] - dsh : rem_reg[s-1];
                q_reg[s]    <= q_reg[s-1] | (take ? Q_W'(1) << (Q_W - s) : '0);
                dmag_reg[s] <= dmag_reg[s-1];
                cof_reg[s]  <= cof_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                inv_reg[s]  <= inv_reg[s-1];
            end
        end
    end

    always_comb
    begin
        logic [C_W-1:0] c;
        logic [Q_W-1:0] q;
        logic           ng;
        c  = cof_reg[DIV_ST];
        q  = q_reg[DIV_ST];
        ng = neg_reg[DIV_ST];
        res_next.sat = 1'b0;
        res_next.val = '0;
        if (!inv_reg[DIV_ST])
        begin
            // singular: unscaled adjugate, clipped
            if ((&c[C_W-1:OUT_W-1]) || !(|c[C_W-1:OUT_W-1]))
                res_next.val = c[OUT_W-1:0];
            else
            begin
                res_next.sat = 1'b1;
                res_next.val = {c[C_W-1], {(OUT_W-1){~c[C_W-1]}}};
            end
        end
        else if (ovf_reg[DIV_ST])
        begin
            res_next.sat = 1'b1;
            res_next.val = {ng, {(OUT_W-1){~ng}}};
        end
        else if (!ng)
        begin
            if (q[Q_W-1])
            begin
                res_next.sat = 1'b1;
                res_next.val = {1'b0, {(OUT_W-1){1'b1}}};
            end
            else
                res_next.val = q;
        end
        else
        begin
            if (q[Q_W-1] && (|q[Q_W-2:0]))
            begin
                res_next.sat = 1'b1;
                res_next.val = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
                res_next.val = -q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LANE_ST-1])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: src/matrix_inverse_3x3_core.sv
// Top level of the 3x3 matrix inverse core: front end, nine division lanes, merge.
// Depends on mit_pkg, mit_if, mit_front, mit_lane and the assertion macro header.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-------------------------------------
//  mat_in    | in  | valid / ready    | a00..a22, signed Q8.8
//  res_out   | out | valid / ready    | r00..r22 Q16.16, invertible, saturated
//  cfg       | in  | cfg_we           | cfg_wdata = zero_threshold (24 bit)
//
// One matrix per cycle sustained while res_out is ready. Pipeline: 5 front-end stages, one
// lane set-up stage, 32 quotient stages at one bit each, one output register.
// The 32-stage restoring divider in each lane sets the latency.
// rst_n (async, active low) clears the stage valid bits and zero_threshold.
// Each stage holds while the one after it is full and stalled; empty stages close up,
// so items are still accepted while a result waits at the output.
`include "matrix_inverse_3x3_core_macros.svh"

module matrix_inverse_3x3_core #(
    parameter int ELEM_WIDTH = mit_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mit_pkg::THR_W-1:0]   cfg_wdata,
    mit_in_if.sink                      mat_in,
    mit_out_if.source                   res_out
);
    import mit_pkg::*;

    logic [THR_W-1:0]            thr_reg;
    logic [NST-1:0]              vld_reg;
    logic [NST-1:0]              vld_next;
    logic [NST-1:0]              adv;
    logic [NLANE-1:0][C_W-1:0]   cof;
    det_t                        det;
    lane_res_t                   lres [NLANE];
    logic [NLANE-1:0]            sat_vec;

    // zero threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // stage advance: a stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || res_out.ready;
        for (int k = NST - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
        vld_next = vld_reg;
        for (int k = 0; k < NST; k++)
        begin
            if (adv[k])
                vld_next[k] = (k == 0) ? mat_in.valid : vld_reg[(k == 0) ? 0 : k - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign mat_in.ready = adv[0];

    mit_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk (clk),
        .en  (adv[FRONT_ST-1:0]),
        .mat (mat_in.data),
        .thr (thr_reg),
        .cof (cof),
        .det (det)
    );

    for (genvar g = 0; g < NLANE; g++)
    begin : g_lane
        mit_lane u_lane (
            .clk (clk),
            .en  (adv[NST-1:FRONT_ST]),
            .cof (cof[g]),
            .det (det),
            .res (lres[g])
        );
        assign sat_vec[g] = lres[g].sat;
    end

    // merge: gather lane results, fold the clip flags
    assign res_out.valid           = vld_reg[NST-1];
    assign res_out.data.r00        = lres[0].val;
    assign res_out.data.r01        = lres[1].val;
    assign res_out.data.r02        = lres[2].val;
    assign res_out.data.r10        = lres[3].val;
    assign res_out.data.r11        = lres[4].val;
    assign res_out.data.r12        = lres[5].val;
    assign res_out.data.r20        = lres[6].val;
    assign res_out.data.r21        = lres[7].val;
    assign res_out.data.r22        = lres[8].val;
    assign res_out.data.saturated  = |sat_vec;

    // the invertible flag travels with the lanes; lane 0 carries the copy shown
    logic inv_out_reg;
    always_ff @(posedge clk)
    begin
        if (adv[NST-1])
            inv_out_reg <= g_lane[0].u_lane.inv_reg[DIV_ST];
    end
    assign res_out.data.invertible = inv_out_reg;

    `MIT_ASSERT_NEXT(a_accept_fills, mat_in.valid && mat_in.ready, vld_reg[0], "accepted item not in first stage")
    `MIT_ASSERT_NOW(a_full_when_blocked, !mat_in.ready, &vld_reg, "input blocked with an empty stage")
    `MIT_ASSERT_NOW(a_hold_on_stall, vld_reg[NST-1] && !res_out.ready, !adv[NST-1], "output stage moved while stalled")

endmodule

// File: tb/tb_top.sv
// Testbench for matrix_inverse_3x3_core: checks each adjugate/inverse result against a predictor.
// Depends on mit_pkg, mit_if and the core RTL.
module tb_top;
    import mit_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    mit_in_if  mat_in ();
    mit_out_if res_out ();

    matrix_inverse_3x3_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mat_in    (mat_in.sink),
        .res_out   (res_out.source)
    );

    // 2-unit period: high 1, low 1
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor's copy of the register
    logic [THR_W-1:0] thresh_model;
    out_t             inverse_q[$];
    int               error_count;
    int               result_count;
    int               singular_seen;
    int               sat_seen;

    // receiver stall control
    bit  hold_off;
    int  stall_pct;

    // sender burst control
    int  gap_max;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $time);
        error_count++;
    endtask

    function automatic logic signed [31:0] clip32(input logic signed [127:0] v,
                                                   inout bit sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // adjugate, determinant and scaled inverse, all in wide signed arithmetic
    function automatic out_t predict_inverse(input in_t m);
        logic signed [63:0]  a[9];
        logic signed [63:0]  cof[9];
        logic signed [127:0] det;
        logic signed [127:0] mag;
        logic signed [127:0] v;
        logic signed [31:0]  r[9];
        bit                  inv;
        bit                  sat;
        out_t                o;
        sat = 1'b0;
        a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
        a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
        a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
        cof[0] = a[4]*a[8] - a[5]*a[7];
        cof[1] = a[2]*a[7] - a[1]*a[8];
        cof[2] = a[1]*a[5] - a[2]*a[4];
        cof[3] = a[5]*a[6] - a[3]*a[8];
        cof[4] = a[0]*a[8] - a[2]*a[6];
        cof[5] = a[2]*a[3] - a[0]*a[5];
        cof[6] = a[3]*a[7] - a[4]*a[6];
        cof[7] = a[1]*a[6] - a[0]*a[7];
        cof[8] = a[0]*a[4] - a[1]*a[3];
        det = 128'(a[0]) * cof[0] + 128'(a[1]) * cof[3] + 128'(a[2]) * cof[6];
        mag = det < 0 ? -det : det;
        inv = mag > $signed({104'd0, thresh_model});
        for (int i = 0; i < 9; i++)
        begin
            v = cof[i];
            // SV signed division truncates toward zero
            if (inv)
                v = (v <<< 24) / det;
            r[i] = clip32(v, sat);
        end
        o = '{r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], inv, sat};
        return o;
    endfunction

    // single-item sender; data changes on the falling edge
    task automatic send_matrix(input in_t m);
        mat_in.data  <= m;
        mat_in.valid <= 1'b1;
        @(posedge clk);
        while (!mat_in.ready)
            @(posedge clk);
        inverse_q.push_back(predict_inverse(m));
        @(negedge clk);
        if (gap_max > 0 && $urandom_range(0, 3) == 0)
        begin
            mat_in.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clk);
        end
    endtask

    task automatic drain();
        mat_in.valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(negedge clk);
        // let the pipeline empty before any register write
        repeat (45) @(negedge clk);
    endtask

    task automatic write_thresh(input logic [THR_W-1:0] t);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(negedge clk);
        cfg_we    <= 1'b0;
        thresh_model = t;
    endtask

    function automatic logic [15:0] rand_elem(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 1024)) - 512);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 16)) - 8) << 8;
        endcase
    endfunction

    function automatic in_t rand_matrix();
        in_t m;
        int  mode;
        mode = $urandom_range(0, 3);
        m = {rand_elem(mode), rand_elem(mode), rand_elem(mode), rand_elem(mode),
             rand_elem(mode), rand_elem(mode), rand_elem(mode), rand_elem(mode),
             rand_elem(mode)};
        // rank-deficient: copy row 0 into row 1
        if ($urandom_range(0, 5) == 0)
            m[95:48] = m[143:96];
        return m;
    endfunction

    // result checker, samples at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && res_out.valid && res_out.ready)
        begin
            out_t g;
            out_t e;
            g = res_out.data;
            if (inverse_q.size() == 0)
            begin
                $display("unexpected result at %0t", $time);
                error_count++;
            end
            else
            begin
                e = inverse_q.pop_front();
                if (g.r00 !== e.r00) report("r00", g.r00, e.r00);
                if (g.r01 !== e.r01) report("r01", g.r01, e.r01);
                if (g.r02 !== e.r02) report("r02", g.r02, e.r02);
                if (g.r10 !== e.r10) report("r10", g.r10, e.r10);
                if (g.r11 !== e.r11) report("r11", g.r11, e.r11);
                if (g.r12 !== e.r12) report("r12", g.r12, e.r12);
                if (g.r20 !== e.r20) report("r20", g.r20, e.r20);
                if (g.r21 !== e.r21) report("r21", g.r21, e.r21);
                if (g.r22 !== e.r22) report("r22", g.r22, e.r22);
                if (g.invertible !== e.invertible)
                    report("invertible", g.invertible, e.invertible);
                if (g.saturated !== e.saturated)
                    report("saturated", g.saturated, e.saturated);
                result_count++;
                if (!e.invertible) singular_seen++;
                if (e.saturated) sat_seen++;
            end
        end
    end

    // receiver stall pattern, changed on the falling edge
    always @(negedge clk)
    begin
        if (hold_off)
            res_out.ready <= 1'b0;
        else
            res_out.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic test_directed();
        in_t m;
        gap_max = 0;
        send_matrix('0);
        // identity and a diagonal matrix
        send_matrix({16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
        send_matrix({16'hff00, 16'h0, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'h0, 16'h0080});
        // tiny determinant: huge inverse
        send_matrix({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001});
        send_matrix({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000, 16'h8000});
        send_matrix({16'h7fff, 16'h8000, 16'h0, 16'h8000, 16'h7fff, 16'h8000,
                     16'h0, 16'h8000, 16'h7fff});
        send_matrix({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000});
        send_matrix({16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff});
        send_matrix({16'hffff, 16'h5555, 16'haaaa, 16'h1234, 16'hfedc, 16'h0f0f,
                     16'hf0f0, 16'h0001, 16'h8001});
        // negative determinant, inexact quotients
        send_matrix({16'h0, 16'h0300, 16'h0, 16'h0700, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0500});
        for (int i = 0; i < 8; i++)
        begin
            m = rand_matrix();
            send_matrix(m);
        end
        drain();
    endtask

    task automatic test_threshold(input logic [THR_W-1:0] t, input int n);
        write_thresh(t);
        // det of diag(1,1,1) in Q8.8 is 2^24; also probe near the threshold
        send_matrix({16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
        send_matrix({16'h0010, 16'h0, 16'h0, 16'h0, 16'h0010, 16'h0, 16'h0, 16'h0, 16'h0010});
        gap_max = 6;
        for (int i = 0; i < n; i++)
            send_matrix(rand_matrix());
        drain();
    endtask

    task automatic test_backpressure();
        gap_max = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (120) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 80; i++)
                send_matrix(rand_matrix());
        join
        drain();
    endtask

    task automatic test_random(input int n);
        gap_max = 10;
        for (int i = 0; i < n; i++)
        begin
            stall_pct = (i % 100 < 30) ? 0 : 40;
            gap_max   = (i % 100 < 20) ? 0 : 10;
            send_matrix(rand_matrix());
        end
        stall_pct = 25;
        drain();
    endtask

    initial
    begin
        #400000;
        $display("timeout at %0t", $time);
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        mat_in.valid  = 1'b0;
        mat_in.data   = '0;
        res_out.ready = 1'b0;
        hold_off      = 1'b0;
        stall_pct     = 25;
        gap_max       = 0;
        thresh_model  = '0;
        error_count   = 0;
        result_count  = 0;
        singular_seen = 0;
        sat_seen      = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_threshold(24'hffffff, 40);
        test_threshold(24'd16777214, 30);
        test_threshold(24'h000400, 30);
        test_threshold(24'd0, 30);
        test_backpressure();
        test_random(260);
        $display("%0d results checked; %0d singular, %0d saturated; threshold 0 to max",
                 result_count, singular_seen, sat_seen);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/mit_pkg.sv
src/mit_if.sv
src/mit_front.sv
src/mit_lane.sv
src/matrix_inverse_3x3_core.sv
tb/tb_top.sv
